// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Opcodes, status codes, pipeline payloads and per-lane divider helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int XW         = 32;          // operand / result word
  localparam int PW         = 2 * XW;      // product width
  localparam int SW         = PW + 2;      // exact sum of two products
  localparam int DEN_W      = PW;          // divisor width
  localparam int QB         = XW;          // quotient bits computed
  localparam int DIV_STEPS  = 2;           // quotient bits per divider stage
  localparam int DIV_STAGES = QB / DIV_STEPS;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_ADDR = 3'd4;
  localparam logic [2:0] OP_MULR = 3'd5;
  localparam logic [2:0] OP_DIVR = 3'd6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef logic signed [XW-1:0] word_t;

  typedef struct packed {
    logic [2:0] op;
    word_t      a_re;
    word_t      a_im;
    word_t      b_re;
    word_t      b_im;
  } cau_req_t;

  typedef struct packed {
    logic [2:0]           op;
    word_t                a_re;
    word_t                a_im;
    word_t                b_re;
    word_t                b_im;
    logic signed [PW-1:0] p_rr;   // a_re * b_re
    logic signed [PW-1:0] p_ii;   // a_im * b_im
    logic signed [PW-1:0] p_ri;   // a_re * b_im
    logic signed [PW-1:0] p_ir;   // a_im * b_re
    logic signed [PW-1:0] s_rr;   // b_re^2
    logic signed [PW-1:0] s_ii;   // b_im^2
  } cau_prod_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [XW:0]   lin_re;
    logic signed [XW:0]   lin_im;
    logic signed [SW-1:0] wide_re;  // product sum or divide numerator
    logic signed [SW-1:0] wide_im;
    logic [DEN_W-1:0]     den;
  } cau_sum_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;          // quotient known to be >= 2^QB
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    nlo;          // numerator bits still to shift in
    logic [QB-1:0]    quo;
  } cau_lane_t;

  typedef struct packed {
    logic [2:0]       op;
    logic             dz;
    logic             sat;
    word_t            re;
    word_t            im;
    logic [DEN_W-1:0] den;
    cau_lane_t        lr;
    cau_lane_t        li;
  } cau_pipe_t;

  typedef struct packed {
    logic [1:0] status;
    word_t      re;
    word_t      im;
  } cau_res_t;

  // saturate a wide signed value to one word; top bit is the saturation flag
  function automatic logic [XW:0] clamp_w(input logic signed [SW-1:0] v);
    logic ov;
    logic [XW-1:0] w;
    ov = !((&v[SW-1:XW-1]) || !(|v[SW-1:XW-1]));
    if (ov) begin
      w = v[SW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
    end else begin
      w = v[XW-1:0];
    end
    return {ov, w};
  endfunction

  // one restoring division step
  function automatic cau_lane_t div_step(input cau_lane_t l, input logic [DEN_W-1:0] d);
    logic [DEN_W:0] t;
    cau_lane_t o;
    o = l;
    t = {l.rem, l.nlo[QB-1]};
    if (t >= {1'b0, d}) begin
      o.rem = DEN_W'(t - {1'b0, d});
      o.quo = {l.quo[QB-2:0], 1'b1};
    end else begin
      o.rem = t[DEN_W-1:0];
      o.quo = {l.quo[QB-2:0], 1'b0};
    end
    o.nlo = {l.nlo[QB-2:0], 1'b0};
    return o;
  endfunction

  // limit, sign and saturation flag of a finished quotient
  function automatic logic [XW:0] div_finish(input cau_lane_t l);
    logic [QB-1:0] lim;
    logic [QB-1:0] qv;
    logic sat;
    lim = l.neg ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    sat = l.ovf || (l.quo > lim);
    qv  = sat ? lim : l.quo;
    return {sat, (l.neg ? XW'(-qv) : XW'(qv))};
  endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front: product and sum stages
// Stage 1 forms all six 32x32 products, stage 2 adds them per opcode.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cau_pkg::cau_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cau_pkg::cau_sum_t out_data
);
  import cau_pkg::*;

  cau_prod_t prod;
  cau_prod_t prod_next;
  logic      prod_vld;
  logic      prod_rdy;
  cau_sum_t  sum;
  cau_sum_t  sum_next;
  logic      sum_vld;

  assign prod_rdy  = !sum_vld || out_ready;
  assign in_ready  = !prod_vld || prod_rdy;
  assign out_valid = sum_vld;
  assign out_data  = sum;

  always_comb begin
    prod_next      = '0;
    prod_next.op   = in_data.op;
    prod_next.a_re = in_data.a_re;
    prod_next.a_im = in_data.a_im;
    prod_next.b_re = in_data.b_re;
    prod_next.b_im = in_data.b_im;
    prod_next.p_rr = in_data.a_re * in_data.b_re;
    prod_next.p_ii = in_data.a_im * in_data.b_im;
    prod_next.p_ri = in_data.a_re * in_data.b_im;
    prod_next.p_ir = in_data.a_im * in_data.b_re;
    prod_next.s_rr = in_data.b_re * in_data.b_re;
    prod_next.s_ii = in_data.b_im * in_data.b_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else if (in_ready) begin
      prod_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod <= prod_next;
    end
  end

  always_comb begin
    logic signed [XW:0] ar;
    logic signed [XW:0] ai;
    logic signed [XW:0] br;
    logic signed [XW:0] bi;
    ar = {prod.a_re[XW-1], prod.a_re};
    ai = {prod.a_im[XW-1], prod.a_im};
    br = {prod.b_re[XW-1], prod.b_re};
    bi = {prod.b_im[XW-1], prod.b_im};
    sum_next        = '0;
    sum_next.op     = prod.op;
    sum_next.lin_re = (prod.op == OP_SUB) ? ar - br : ar + br;
    if (prod.op == OP_SUB) begin
      sum_next.lin_im = ai - bi;
    end else if (prod.op == OP_ADDR) begin
      sum_next.lin_im = ai;
    end else begin
      sum_next.lin_im = ai + bi;
    end
    sum_next.den = DEN_W'($unsigned(prod.s_rr)) + DEN_W'($unsigned(prod.s_ii));
    case (prod.op)
      OP_MUL: begin
        sum_next.wide_re = SW'(prod.p_rr) - SW'(prod.p_ii);
        sum_next.wide_im = SW'(prod.p_ri) + SW'(prod.p_ir);
      end
      OP_MULR: begin
        sum_next.wide_re = SW'(prod.p_rr);
        sum_next.wide_im = SW'(prod.p_ir);
      end
      OP_DIV: begin
        sum_next.wide_re = SW'(prod.p_rr) + SW'(prod.p_ii);
        sum_next.wide_im = SW'(prod.p_ir) - SW'(prod.p_ri);
      end
      OP_DIVR: begin
        // fold the divisor sign into the numerator
        sum_next.wide_re = br[XW] ? -SW'(ar) : SW'(ar);
        sum_next.wide_im = br[XW] ? -SW'(ai) : SW'(ai);
        sum_next.den     = DEN_W'(br[XW] ? -br : br);
      end
      default: begin
        sum_next.wide_re = '0;
        sum_next.wide_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else if (prod_rdy) begin
      sum_vld <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_rdy && prod_vld) begin
      sum <= sum_next;
    end
  end

endmodule

// ===== hw/rtl/cau_prep.sv =====
// ----------------------------------------------------------------------------
// cau_prep: scaling, clamping and divider setup
// Finishes add/sub/multiply results and loads both divider lanes.
// ----------------------------------------------------------------------------
module cau_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cau_pkg::cau_sum_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cau_pkg::cau_pipe_t out_data
);
  import cau_pkg::*;

  localparam int NW = DEN_W + FRAC_BITS;

  cau_pipe_t pipe;
  cau_pipe_t pipe_next;
  logic      vld;

  function automatic cau_lane_t lane_init(input logic signed [SW-1:0] num,
                                          input logic [DEN_W-1:0] d);
    logic signed [SW-1:0] mag;
    logic [NW-1:0] nn;
    logic [NW-QB-1:0] hi;
    cau_lane_t l;
    mag   = num[SW-1] ? -num : num;
    nn    = NW'(mag[DEN_W-1:0]) << FRAC_BITS;
    hi    = nn[NW-1:QB];
    l.neg = num[SW-1];
    l.ovf = DEN_W'(hi) >= d;
    l.rem = DEN_W'(hi);
    l.nlo = nn[QB-1:0];
    l.quo = '0;
    return l;
  endfunction

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = pipe;

  always_comb begin
    logic [XW:0] cre;
    logic [XW:0] cim;
    logic is_div;
    is_div         = (in_data.op == OP_DIV) || (in_data.op == OP_DIVR);
    pipe_next      = '0;
    pipe_next.op   = in_data.op;
    pipe_next.den  = in_data.den;
    pipe_next.dz   = is_div && (in_data.den == '0);
    pipe_next.lr   = lane_init(in_data.wide_re, in_data.den);
    pipe_next.li   = lane_init(in_data.wide_im, in_data.den);
    cre = clamp_w(in_data.wide_re >>> FRAC_BITS);
    cim = clamp_w(in_data.wide_im >>> FRAC_BITS);
    if (in_data.op == OP_ADD || in_data.op == OP_SUB || in_data.op == OP_ADDR) begin
      cre = clamp_w(SW'(in_data.lin_re));
      cim = clamp_w(SW'(in_data.lin_im));
    end
    if (in_data.op == OP_ADD || in_data.op == OP_SUB || in_data.op == OP_ADDR ||
        in_data.op == OP_MUL || in_data.op == OP_MULR) begin
      pipe_next.re  = cre[XW-1:0];
      pipe_next.im  = cim[XW-1:0];
      pipe_next.sat = cre[XW] || cim[XW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pipe <= pipe_next;
    end
  end

endmodule

// ===== hw/rtl/cau_div_stage.sv =====
// ----------------------------------------------------------------------------
// cau_div_stage: one stage of the pipelined restoring divider
// Retires DIV_STEPS quotient bits on both lanes.
// ----------------------------------------------------------------------------
module cau_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cau_pkg::cau_pipe_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cau_pkg::cau_pipe_t out_data
);
  import cau_pkg::*;

  cau_pipe_t pipe;
  cau_pipe_t pipe_next;
  logic      vld;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = pipe;

  always_comb begin
    pipe_next = in_data;
    for (int k = 0; k < DIV_STEPS; k++) begin
      pipe_next.lr = div_step(pipe_next.lr, pipe_next.den);
      pipe_next.li = div_step(pipe_next.li, pipe_next.den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pipe <= pipe_next;
    end
  end

endmodule

// ===== hw/rtl/cau_out.sv =====
// ----------------------------------------------------------------------------
// cau_out: result select and output register
// Saturates quotients, applies divide-by-zero and builds the status.
// ----------------------------------------------------------------------------
module cau_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cau_pkg::cau_pipe_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cau_pkg::cau_res_t  out_data
);
  import cau_pkg::*;

  cau_res_t res;
  cau_res_t res_next;
  logic     vld;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = res;

  always_comb begin
    logic [XW:0] qre;
    logic [XW:0] qim;
    qre = div_finish(in_data.lr);
    qim = div_finish(in_data.li);
    res_next.re     = in_data.re;
    res_next.im     = in_data.im;
    res_next.status = in_data.sat ? ST_SAT : ST_OK;
    if (in_data.op == OP_DIV || in_data.op == OP_DIVR) begin
      if (in_data.dz) begin
        res_next.re     = '0;
        res_next.im     = '0;
        res_next.status = ST_DZ;
      end else begin
        res_next.re     = qre[XW-1:0];
        res_next.im     = qim[XW-1:0];
        res_next.status = (qre[XW] || qim[XW]) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
    end
  end

endmodule

// ===== hw/rtl/complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top: pipelined Q16.16 complex arithmetic unit
//
// Input stream (s_*): one word per operation. s_tuser carries the opcode
// (add, sub, mul, div, add real, mul real, div real); s_tdata carries the
// operands a_re, a_im, b_re, b_im. Real-operand ops take the scalar in b_re.
// Output stream (m_*): one word per input word, in order. m_tdata holds
// res_re and res_im, m_tuser the status (ok, divide by zero, saturated).
//
// Twenty register stages: products, sums, scaling and divider setup,
// 16 divider stages (two quotient bits each) and the output register. A word
// passes through them in that order and is held in each register until the
// next stage takes it. The pipeline takes one word per cycle unless a stalled
// receiver has filled it, every operation through the same path.
// Every stage has its own valid bit and a ready that passes back through
// empty stages, so bubbles are squeezed out while the receiver stalls and
// input is still taken until the pipeline is full. Nothing is dropped.
// Reset clears all valid bits; no state survives between words.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
  input  logic [2:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // res_re, res_im
  output logic [1:0]   m_tuser    // status
);
  import cau_pkg::*;

  cau_req_t  req;
  cau_sum_t  sum;
  logic      sum_vld;
  logic      sum_rdy;
  cau_pipe_t dpipe [DIV_STAGES+1];
  logic      dvld  [DIV_STAGES+1];
  logic      drdy  [DIV_STAGES+1];
  cau_res_t  res;

  // unpack the input word
  assign req.op   = s_tuser;
  assign req.a_re = s_tdata[XW-1:0];
  assign req.a_im = s_tdata[2*XW-1:XW];
  assign req.b_re = s_tdata[3*XW-1:2*XW];
  assign req.b_im = s_tdata[4*XW-1:3*XW];

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (req),
    .out_valid (sum_vld),
    .out_ready (sum_rdy),
    .out_data  (sum)
  );

  cau_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_vld),
    .in_ready  (sum_rdy),
    .in_data   (sum),
    .out_valid (dvld[0]),
    .out_ready (drdy[0]),
    .out_data  (dpipe[0])
  );

  // divider chain, two quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    cau_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dvld[g]),
      .in_ready  (drdy[g]),
      .in_data   (dpipe[g]),
      .out_valid (dvld[g+1]),
      .out_ready (drdy[g+1]),
      .out_data  (dpipe[g+1])
    );
  end

  cau_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dvld[DIV_STAGES]),
    .in_ready  (drdy[DIV_STAGES]),
    .in_data   (dpipe[DIV_STAGES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {res.im, res.re};
  assign m_tuser = res.status;

  // divide by zero always returns a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_DZ |-> m_tdata == '0)
    else $error("divide by zero with nonzero result");

  // a saturated result sits at a limit in at least one part
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_SAT |->
      res.re == {1'b0, {(XW-1){1'b1}}} || res.re == {1'b1, {(XW-1){1'b0}}} ||
      res.im == {1'b0, {(XW-1){1'b1}}} || res.im == {1'b1, {(XW-1){1'b0}}})
    else $error("saturation flagged without a limit value");

  // an open output never back-pressures the input
  a_open_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_DZ || m_tuser == ST_SAT)
    else $error("undefined status code");

endmodule
